// File: sv/gpmc_pkg.sv
`timescale 1ns / 1ps

package gpmc_pkg;

    // Field widths
    localparam int PT_W   = 32;
    localparam int COS_W  = 18;
    localparam int CODE_W = 18;
    localparam int IDX_W  = 3;

    // Transform products and angle operands
    localparam int PROD_W = 50;
    localparam int NUM_W  = 54;

    // Vectoring datapath
    localparam int CORD_W   = 58;
    localparam int ANG_W    = 34;
    localparam int SHIFT_W  = 6;
    localparam int NORM_BIT = 52;

    // Angle to code scaling: code = |z| * CODE_MUL / CODE_DEN, truncated
    localparam int MAG_W      = 32;
    localparam int Q_W        = 19;
    localparam int RECIP_W    = 31;
    localparam int RECIP_SH   = 44;
    localparam int DEN_W      = 34;
    localparam int PM_W       = MAG_W + RECIP_W;
    localparam int P_W        = 52;
    localparam int QD_W       = Q_W + DEN_W;
    localparam int REM_W      = QD_W + 1;
    localparam logic [19:0]        CODE_MUL = 20'd589806;
    localparam logic [DEN_W-1:0]   CODE_DEN = 34'd8433148565;
    localparam logic [127:0]       RECIP_FULL =
        ((128'd1 << RECIP_SH) * 128'd589806) / 128'd8433148565;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [Q_W-1:0]     CODE_FULL = 19'd117961;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_ROT_COS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROT_SIN   = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHIFT_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHIFT_Z   = 3'd4;
    localparam logic [IDX_W-1:0] REG_MIRROR_OFF = 3'd5;

    // Result of one angle unit
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              bad;
    } t_angle_res;

    // Arctangent of 2^-i in Q2.30 radians
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// File: sv/gpmc_xform.sv
`timescale 1ns / 1ps

module gpmc_xform (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic signed [gpmc_pkg::PT_W-1:0]        i_px,
    input  logic signed [gpmc_pkg::PT_W-1:0]        i_py,
    input  logic signed [gpmc_pkg::PT_W-1:0]        i_pz,
    input  logic signed [gpmc_pkg::COS_W-1:0]       i_cos,
    input  logic signed [gpmc_pkg::COS_W-1:0]       i_sin,
    input  logic signed [gpmc_pkg::PT_W-1:0]        i_shift_x,
    input  logic signed [gpmc_pkg::PT_W-1:0]        i_shift_y,
    input  logic signed [gpmc_pkg::PT_W-1:0]        i_shift_z,
    input  logic signed [gpmc_pkg::PT_W-1:0]        i_offset,
    output logic                                    o_valid,
    output logic signed [gpmc_pkg::NUM_W-1:0]       o_num_x,
    output logic signed [gpmc_pkg::NUM_W-1:0]       o_num_y,
    output logic signed [gpmc_pkg::NUM_W-1:0]       o_den
);

    logic                                    r_v1;
    logic signed [gpmc_pkg::PROD_W-1:0]      r_cpx, r_spy, r_spx, r_cpy;
    logic signed [gpmc_pkg::PT_W:0]          r_offx, r_zs;
    logic signed [gpmc_pkg::PT_W-1:0]        r_shy;

    // Stage one: the four rotation products and the constant sums.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cpx  <= i_cos * i_px;
            r_spy  <= i_sin * i_py;
            r_spx  <= i_sin * i_px;
            r_cpy  <= i_cos * i_py;
            r_offx <= (gpmc_pkg::PT_W+1)'(i_shift_x) - (gpmc_pkg::PT_W+1)'(i_offset);
            r_zs   <= (gpmc_pkg::PT_W+1)'(i_pz) + (gpmc_pkg::PT_W+1)'(i_shift_z);
            r_shy  <= i_shift_y;
        end
    end

    // Stage two: rotated and translated coordinates in Q.32.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num_x <= gpmc_pkg::NUM_W'(r_cpx) - gpmc_pkg::NUM_W'(r_spy)
                       + (gpmc_pkg::NUM_W'(r_offx) <<< 16);
            o_den   <= gpmc_pkg::NUM_W'(r_spx) + gpmc_pkg::NUM_W'(r_cpy)
                       + (gpmc_pkg::NUM_W'(r_shy) <<< 16);
            o_num_y <= gpmc_pkg::NUM_W'(r_zs) <<< 16;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

endmodule

// File: sv/gpmc_angle.sv
`timescale 1ns / 1ps

module gpmc_angle #(
    parameter int ITER = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [gpmc_pkg::NUM_W-1:0]  i_num,
    input  logic signed [gpmc_pkg::NUM_W-1:0]  i_den,
    output logic                               o_valid,
    output gpmc_pkg::t_angle_res               o_res
);

    localparam int NW = gpmc_pkg::NUM_W;
    localparam int CW = gpmc_pkg::CORD_W;
    localparam int AW = gpmc_pkg::ANG_W;
    localparam int SW = gpmc_pkg::SHIFT_W;

    // Fold the denominator sign into the numerator.
    logic signed [NW-1:0] n_x, n_y, n_ym;
    always_comb begin
        n_x  = i_den[NW-1] ? -i_den : i_den;
        n_y  = i_den[NW-1] ? -i_num : i_num;
        n_ym = n_y[NW-1] ? -n_y : n_y;
    end

    logic                 r1_v, r1_dz, r1_nz, r1_ns;
    logic signed [NW-1:0] r1_x, r1_y;
    logic [NW-1:0]        r1_m;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x  <= n_x;
            r1_y  <= n_y;
            r1_m  <= n_x | n_ym;
            r1_dz <= (i_den == '0);
            r1_nz <= (i_num == '0);
            r1_ns <= i_num[NW-1];
        end
    end

    // Leading one of the larger magnitude sets the normalizing shift.
    logic [SW-1:0] n_p, n_k;
    always_comb begin
        n_p = '0;
        for (int b = 0; b < NW; b++) begin
            if (r1_m[b]) begin
                n_p = SW'(b);
            end
        end
        n_k = (n_p >= SW'(gpmc_pkg::NORM_BIT)) ? '0 : SW'(gpmc_pkg::NORM_BIT) - n_p;
    end

    logic                 r2_v, r2_dz, r2_nz, r2_ns;
    logic signed [NW-1:0] r2_x, r2_y;
    logic [SW-1:0]        r2_k;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_k  <= n_k;
            r2_dz <= r1_dz;
            r2_nz <= r1_nz;
            r2_ns <= r1_ns;
        end
    end

    // Vectoring stages, one rotation each.
    logic signed [CW-1:0] c_x [0:ITER];
    logic signed [CW-1:0] c_y [0:ITER];
    logic signed [AW-1:0] c_z [0:ITER];
    logic                 c_v  [0:ITER];
    logic                 c_dz [0:ITER];
    logic                 c_nz [0:ITER];
    logic                 c_ns [0:ITER];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            c_x[0]  <= CW'(r2_x) <<< r2_k;
            c_y[0]  <= CW'(r2_y) <<< r2_k;
            c_z[0]  <= '0;
            c_dz[0] <= r2_dz;
            c_nz[0] <= r2_nz;
            c_ns[0] <= r2_ns;
        end
    end

    for (genvar i = 0; i < ITER; i++) begin : g_rot
        logic signed [CW-1:0] sx, sy;
        logic signed [AW-1:0] step;
        assign sx   = c_x[i] >>> i;
        assign sy   = c_y[i] >>> i;
        assign step = $signed({2'b00, gpmc_pkg::atan_entry(5'(i))});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!c_y[i][CW-1]) begin
                    c_x[i+1] <= c_x[i] + sy;
                    c_y[i+1] <= c_y[i] - sx;
                    c_z[i+1] <= c_z[i] + step;
                end else begin
                    c_x[i+1] <= c_x[i] - sy;
                    c_y[i+1] <= c_y[i] + sx;
                    c_z[i+1] <= c_z[i] - step;
                end
                c_dz[i+1] <= c_dz[i];
                c_nz[i+1] <= c_nz[i];
                c_ns[i+1] <= c_ns[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                c_v[i+1] <= 1'b0;
            end else if (i_en) begin
                c_v[i+1] <= c_v[i];
            end
        end
    end

    // Scale stage one: magnitude times the reciprocal and times the numerator.
    logic [gpmc_pkg::MAG_W-1:0] n_a;
    assign n_a = c_z[ITER][AW-1] ? gpmc_pkg::MAG_W'(-c_z[ITER])
                                 : gpmc_pkg::MAG_W'(c_z[ITER]);

    logic                        r5_v, r5_dz, r5_nz, r5_ns, r5_zs;
    logic [gpmc_pkg::PM_W-1:0]   r5_pm;
    logic [gpmc_pkg::P_W-1:0]    r5_p;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_pm <= gpmc_pkg::PM_W'(n_a) * gpmc_pkg::PM_W'(gpmc_pkg::RECIP);
            r5_p  <= gpmc_pkg::P_W'(n_a) * gpmc_pkg::P_W'(gpmc_pkg::CODE_MUL);
            r5_zs <= c_z[ITER][AW-1];
            r5_dz <= c_dz[ITER];
            r5_nz <= c_nz[ITER];
            r5_ns <= c_ns[ITER];
        end
    end

    // Scale stage two: estimated quotient times the divisor.
    logic [gpmc_pkg::Q_W-1:0] n_qe;
    assign n_qe = r5_pm[gpmc_pkg::RECIP_SH +: gpmc_pkg::Q_W];

    logic                       r6_v, r6_dz, r6_nz, r6_ns, r6_zs;
    logic [gpmc_pkg::Q_W-1:0]   r6_qe;
    logic [gpmc_pkg::QD_W-1:0]  r6_qd;
    logic [gpmc_pkg::P_W-1:0]   r6_p;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_qe <= n_qe;
            r6_qd <= gpmc_pkg::QD_W'(n_qe) * gpmc_pkg::QD_W'(gpmc_pkg::CODE_DEN);
            r6_p  <= r5_p;
            r6_zs <= r5_zs;
            r6_dz <= r5_dz;
            r6_nz <= r5_nz;
            r6_ns <= r5_ns;
        end
    end

    // Scale stage three: the estimate is at most one low; fix it from the remainder.
    logic [gpmc_pkg::REM_W-1:0] n_rem;
    assign n_rem = gpmc_pkg::REM_W'(r6_p) - gpmc_pkg::REM_W'(r6_qd);

    logic                     r7_v, r7_dz, r7_nz, r7_ns, r7_zs;
    logic [gpmc_pkg::Q_W-1:0] r7_q;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_q  <= (n_rem >= gpmc_pkg::REM_W'(gpmc_pkg::CODE_DEN)) ? r6_qe + 1'b1 : r6_qe;
            r7_zs <= r6_zs;
            r7_dz <= r6_dz;
            r7_nz <= r6_nz;
            r7_ns <= r6_ns;
        end
    end

    // Saturate, restore the sign, and apply the zero-denominator and zero-numerator cases.
    logic [gpmc_pkg::Q_W-1:0]    n_qs;
    logic [gpmc_pkg::CODE_W-1:0] n_mag, n_full;
    gpmc_pkg::t_angle_res        n_res;
    always_comb begin
        n_qs   = (r7_q > gpmc_pkg::CODE_FULL) ? gpmc_pkg::CODE_FULL : r7_q;
        n_mag  = gpmc_pkg::CODE_W'(n_qs);
        n_full = gpmc_pkg::CODE_W'(gpmc_pkg::CODE_FULL);
        n_res.bad  = 1'b0;
        n_res.code = r7_zs ? -n_mag : n_mag;
        if (r7_dz) begin
            if (r7_nz) begin
                n_res.bad  = 1'b1;
                n_res.code = '0;
            end else begin
                n_res.code = r7_ns ? -n_full : n_full;
            end
        end else if (r7_nz) begin
            n_res.code = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
        end
    end

    // Valid bits for the non-generated stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            c_v[0]  <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            c_v[0]  <= r2_v;
            r5_v    <= c_v[ITER];
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            o_valid <= r7_v;
        end
    end

    // Zero over zero always reports invalid with a zero code.
    a_zero_over_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r7_v && r7_dz && r7_nz) |=> (o_res.bad && o_res.code == '0))
        else $error("zero over zero not flagged");

endmodule

// File: sv/galvo_point_to_mirror_code.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake                  Contents
// s_axis     in         i_s_tvalid / o_s_tready    point_x, point_y, point_z
// m_axis     out        o_m_tvalid / i_m_tready    x_code, y_code; invalid in tuser
// cfg        in         i_cfg_valid / o_cfg_ready  register index and write data
//
// One item enters per cycle while the output is not stalled; each result passes through
// two transform stages, three normalize stages, one stage per rotation step and four
// scaling stages. The rotation chain sets that depth.
// Reset is synchronous and active low; it clears all valid bits and loads the register
// reset values. A stalled output holds the whole pipeline in place.

module galvo_point_to_mirror_code #(
    parameter int ANGLE_ITERATIONS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [95:0]                      i_s_tdata,  // point_x, point_y, point_z
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [39:0]                      o_m_tdata,  // x_code, y_code, zero fill
    output logic [0:0]                       o_m_tuser,  // invalid
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gpmc_pkg::IDX_W-1:0]       i_cfg_addr,
    input  logic [31:0]                      i_cfg_data
);

    localparam int PW = gpmc_pkg::PT_W;
    localparam int CW = gpmc_pkg::CODE_W;

    // Transform registers.
    logic signed [gpmc_pkg::COS_W-1:0] r_rot_cos, r_rot_sin;
    logic signed [PW-1:0]              r_shift_x, r_shift_y, r_shift_z, r_mirror_off;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_cos    <= 18'sd65536;
            r_rot_sin    <= '0;
            r_shift_x    <= '0;
            r_shift_y    <= '0;
            r_shift_z    <= '0;
            r_mirror_off <= 32'sd1376256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                gpmc_pkg::REG_ROT_COS:    r_rot_cos    <= i_cfg_data[gpmc_pkg::COS_W-1:0];
                gpmc_pkg::REG_ROT_SIN:    r_rot_sin    <= i_cfg_data[gpmc_pkg::COS_W-1:0];
                gpmc_pkg::REG_SHIFT_X:    r_shift_x    <= i_cfg_data;
                gpmc_pkg::REG_SHIFT_Y:    r_shift_y    <= i_cfg_data;
                gpmc_pkg::REG_SHIFT_Z:    r_shift_z    <= i_cfg_data;
                gpmc_pkg::REG_MIRROR_OFF: r_mirror_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a result waits unaccepted.
    logic w_en, w_vx, w_vy, w_xv;
    logic signed [gpmc_pkg::NUM_W-1:0] w_num_x, w_num_y, w_den;
    gpmc_pkg::t_angle_res w_rx, w_ry;

    assign w_en       = !w_vx || i_m_tready;
    assign o_s_tready = w_en;

    gpmc_xform u_xform (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_tvalid),
        .i_px      (i_s_tdata[PW-1:0]),
        .i_py      (i_s_tdata[2*PW-1:PW]),
        .i_pz      (i_s_tdata[3*PW-1:2*PW]),
        .i_cos     (r_rot_cos),
        .i_sin     (r_rot_sin),
        .i_shift_x (r_shift_x),
        .i_shift_y (r_shift_y),
        .i_shift_z (r_shift_z),
        .i_offset  (r_mirror_off),
        .o_valid   (w_xv),
        .o_num_x   (w_num_x),
        .o_num_y   (w_num_y),
        .o_den     (w_den)
    );

    gpmc_angle #(.ITER(ANGLE_ITERATIONS)) u_angle_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_xv),
        .i_num   (w_num_x),
        .i_den   (w_den),
        .o_valid (w_vx),
        .o_res   (w_rx)
    );

    gpmc_angle #(.ITER(ANGLE_ITERATIONS)) u_angle_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_xv),
        .i_num   (w_num_y),
        .i_den   (w_den),
        .o_valid (w_vy),
        .o_res   (w_ry)
    );

    assign o_m_tvalid = w_vx;
    assign o_m_tdata  = {4'b0000, w_ry.code, w_rx.code};
    assign o_m_tuser  = w_rx.bad | w_ry.bad;

    // Both angle units run in lockstep.
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vx == w_vy)
        else $error("angle units out of step");

    // A flagged item has at least one zero code.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (w_rx.code == '0 || w_ry.code == '0))
        else $error("invalid item without zero code");

    // Codes stay inside the full-scale range.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(w_rx.code) <= 18'sd117961 &&
                        $signed(w_rx.code) >= -18'sd117961 &&
                        $signed(w_ry.code) <= 18'sd117961 &&
                        $signed(w_ry.code) >= -18'sd117961))
        else $error("code out of range");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("item present after reset");

endmodule
